@@ src/acm_pkg.sv @@
// acm_pkg: shared codes and the command/status types between the matcher
// controller and datapath. No dependencies.
package acm_pkg;

    localparam int PID_W = 10;
    localparam int CNT_W = 16;
    localparam int NUM_W = 11;

    localparam logic REG_PATTERN_LENGTH = 1'b0;
    localparam logic REG_ALPHABET_SIZE  = 1'b1;

    localparam logic [1:0] MODE_PATTERN = 2'd0;
    localparam logic [1:0] MODE_BUILD   = 2'd1;
    localparam logic [1:0] MODE_TEXT    = 2'd2;
    localparam logic [1:0] MODE_CLEAR   = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_MATCH  = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_BADSYM = 3'd3;
    localparam logic [2:0] ST_PHASE  = 3'd4;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RES_PHASE,
        OP_RES_BAD_INS,
        OP_RES_BAD_SRCH,
        OP_INS_RD,
        OP_INS_CHK,
        OP_INS_TERM,
        OP_SRCH_RD,
        OP_SRCH_CHK,
        OP_SRCH_FAIL,
        OP_SRCH_TERM,
        OP_ROOT_INIT,
        OP_ROOT_RD,
        OP_ROOT_CHK,
        OP_DEQ,
        OP_CUR,
        OP_CURF,
        OP_SYM_RD,
        OP_SYM_CHK,
        OP_WALK,
        OP_WFAIL,
        OP_BUILD_END,
        OP_SWEEP_START,
        OP_SWEEP,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic ready;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       phase_search;
        logic       bad_sym;
        logic       g_zero;
        logic       full;
        logic       close;
        logic       bsym_last;
        logic       queue_empty;
        logic       sweep_last;
        logic       out_free;
    } stat_t;

endpackage

@@ src/acm_ram.sv @@
// acm_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module acm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/acm_ctrl.sv @@
// acm_ctrl: sequencer of the matcher; issues at most one datapath operation a cycle,
// none while it waits for input or for the result output to free. Depends on acm_pkg.
module acm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  acm_pkg::stat_t stat,
    output acm_pkg::cmd_t  cmd
);
    import acm_pkg::*;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DISP, S_INS_CHK, S_INS_TERM, S_SRCH_CHK, S_SRCH_FAIL,
        S_SRCH_TERM, S_ROOT_RD, S_ROOT_CHK, S_DEQ, S_CUR, S_CURF, S_SYM_RD,
        S_SYM_CHK, S_WALK, S_WFAIL, S_CLR, S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.ready  = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.op = OP_SWEEP;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat.mode)
                    MODE_PATTERN:
                    begin
                        if (stat.phase_search)
                        begin
                            cmd.op     = OP_RES_PHASE;
                            state_next = S_DONE;
                        end
                        else if (stat.bad_sym)
                        begin
                            cmd.op     = OP_RES_BAD_INS;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.op     = OP_INS_RD;
                            state_next = S_INS_CHK;
                        end
                    end
                    MODE_BUILD:
                    begin
                        if (stat.phase_search)
                        begin
                            cmd.op     = OP_RES_PHASE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.op     = OP_ROOT_INIT;
                            state_next = S_ROOT_RD;
                        end
                    end
                    MODE_TEXT:
                    begin
                        if (!stat.phase_search)
                        begin
                            cmd.op     = OP_RES_PHASE;
                            state_next = S_DONE;
                        end
                        else if (stat.bad_sym)
                        begin
                            cmd.op     = OP_RES_BAD_SRCH;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.op     = OP_SRCH_RD;
                            state_next = S_SRCH_CHK;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        cmd.op     = OP_SWEEP_START;
                        state_next = S_CLR;
                    end
                    default: ;
                endcase
            end
            S_INS_CHK:
            begin
                cmd.op = OP_INS_CHK;
                if (!stat.full && stat.close)
                begin
                    state_next = S_INS_TERM;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_INS_TERM:
            begin
                cmd.op     = OP_INS_TERM;
                state_next = S_DONE;
            end
            S_SRCH_CHK:
            begin
                cmd.op     = OP_SRCH_CHK;
                state_next = stat.g_zero ? S_SRCH_FAIL : S_SRCH_TERM;
            end
            S_SRCH_FAIL:
            begin
                cmd.op     = OP_SRCH_FAIL;
                state_next = S_SRCH_CHK;
            end
            S_SRCH_TERM:
            begin
                cmd.op     = OP_SRCH_TERM;
                state_next = S_DONE;
            end
            S_ROOT_RD:
            begin
                cmd.op     = OP_ROOT_RD;
                state_next = S_ROOT_CHK;
            end
            S_ROOT_CHK:
            begin
                cmd.op     = OP_ROOT_CHK;
                state_next = stat.bsym_last ? S_DEQ : S_ROOT_RD;
            end
            S_DEQ:
            begin
                if (stat.queue_empty)
                begin
                    cmd.op     = OP_BUILD_END;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_DEQ;
                    state_next = S_CUR;
                end
            end
            S_CUR:
            begin
                cmd.op     = OP_CUR;
                state_next = S_CURF;
            end
            S_CURF:
            begin
                cmd.op     = OP_CURF;
                state_next = S_SYM_RD;
            end
            S_SYM_RD:
            begin
                cmd.op     = OP_SYM_RD;
                state_next = S_SYM_CHK;
            end
            S_SYM_CHK:
            begin
                cmd.op = OP_SYM_CHK;
                if (!stat.g_zero)
                begin
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = stat.bsym_last ? S_DEQ : S_SYM_RD;
                end
            end
            S_WALK:
            begin
                cmd.op = OP_WALK;
                if (stat.g_zero)
                begin
                    state_next = S_WFAIL;
                end
                else
                begin
                    state_next = stat.bsym_last ? S_DEQ : S_SYM_RD;
                end
            end
            S_WFAIL:
            begin
                cmd.op     = OP_WFAIL;
                state_next = S_WALK;
            end
            S_CLR:
            begin
                cmd.op = OP_SWEEP;
                if (stat.sweep_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/acm_dp.sv @@
// acm_dp: matcher datapath: config registers, cursors, counters, the goto,
// failure, terminal and queue memories, and the result register.
// Depends on acm_pkg and acm_ram.
module acm_dp #(
    parameter int MAX_STATES = 1024,
    parameter int ALPHABET   = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [8:0]    cfg_wdata,
    input  logic [7:0]    s_tdata,
    input  logic [1:0]    s_tuser,
    input  logic          s_tlast,
    input  logic          m_tready,
    input  acm_pkg::cmd_t  cmd,
    output acm_pkg::stat_t stat,
    output logic          m_tvalid,
    output logic [2:0]    m_tuser,
    output logic [63:0]   m_tdata
);
    import acm_pkg::*;

    localparam int SW         = $clog2(MAX_STATES);
    localparam int AW         = $clog2(ALPHABET);
    localparam int GW         = SW + AW;
    localparam int EW         = SW + 1;
    localparam int CW         = SW + 1;
    localparam int GOTO_DEPTH = MAX_STATES * (1 << AW);

    logic [1:0]         mode_reg, mode_next;
    logic [7:0]         sym_reg, sym_next;
    logic               last_reg, last_next;
    logic [7:0]         pl_reg, pl_next;
    logic [8:0]         asz_reg, asz_next;
    logic               phase_reg, phase_next;
    logic [CW-1:0]      sc_reg, sc_next;
    logic [CW-1:0]      pc_reg, pc_next;
    logic [SW-1:0]      ins_cur_reg, ins_cur_next;
    logic [7:0]         ins_off_reg, ins_off_next;
    logic [SW-1:0]      srch_cur_reg, srch_cur_next;
    logic [CNT_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   mat_reg, mat_next;
    logic [SW-1:0]      walk_reg, walk_next;
    logic [SW-1:0]      cur_reg, cur_next;
    logic [SW-1:0]      cur_fail_reg, cur_fail_next;
    logic [SW-1:0]      child_reg, child_next;
    logic [AW-1:0]      bsym_reg, bsym_next;
    logic [CW-1:0]      head_reg, head_next;
    logic [CW-1:0]      tail_reg, tail_next;
    logic [GW-1:0]      swp_reg, swp_next;
    logic [2:0]         res_status_reg, res_status_next;
    logic [PID_W-1:0]   res_pid_reg, res_pid_next;
    logic [CNT_W-1:0]   res_pos_reg, res_pos_next;
    logic [CNT_W-1:0]   res_cnt_reg, res_cnt_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [2:0]         m_tuser_reg, m_tuser_next;
    logic [63:0]        m_tdata_reg, m_tdata_next;

    logic               g_we;
    logic [GW-1:0]      g_waddr, g_raddr;
    logic [EW-1:0]      g_wdata, g_rdata;
    logic               t_we;
    logic [SW-1:0]      t_waddr, t_raddr;
    logic [CW-1:0]      t_wdata, t_rdata;
    logic               f_we;
    logic [SW-1:0]      f_waddr, f_raddr, f_wdata, f_rdata;
    logic               q_we;
    logic [SW-1:0]      q_waddr, q_raddr, q_wdata, q_rdata;

    logic [AW-1:0]      sym_a;
    logic [8:0]         eff_alpha;
    logic               g_zero;
    logic               t_zero;
    logic [SW-1:0]      g_dec;
    logic [SW-1:0]      nxt;
    logic               full;
    logic               close;
    logic               tail_room;
    logic [CNT_W-1:0]   mat_new;

    assign sym_a     = sym_reg[AW-1:0];
    assign eff_alpha = (asz_reg < 9'(ALPHABET)) ? asz_reg : 9'(ALPHABET);
    assign g_zero    = (g_rdata == '0);
    assign t_zero    = (t_rdata == '0);
    assign g_dec     = SW'(g_rdata - EW'(1));
    assign full      = g_zero && (sc_reg >= CW'(MAX_STATES));
    assign nxt       = g_zero ? sc_reg[SW-1:0] : g_dec;
    assign close     = ({1'b0, ins_off_reg} + 9'd1) >= {1'b0, pl_reg};
    assign tail_room = tail_reg < CW'(MAX_STATES);
    assign mat_new   = (!t_zero && mat_reg != '1) ? mat_reg + CNT_W'(1) : mat_reg;

    assign stat.mode         = mode_reg;
    assign stat.phase_search = phase_reg;
    assign stat.bad_sym      = {1'b0, sym_reg} >= eff_alpha;
    assign stat.g_zero       = g_zero;
    assign stat.full         = full;
    assign stat.close        = close;
    assign stat.bsym_last    = bsym_reg == AW'(ALPHABET - 1);
    assign stat.queue_empty  = head_reg == tail_reg;
    assign stat.sweep_last   = swp_reg == GW'(GOTO_DEPTH - 1);
    assign stat.out_free     = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        mode_next       = mode_reg;
        sym_next        = sym_reg;
        last_next       = last_reg;
        pl_next         = pl_reg;
        asz_next        = asz_reg;
        phase_next      = phase_reg;
        sc_next         = sc_reg;
        pc_next         = pc_reg;
        ins_cur_next    = ins_cur_reg;
        ins_off_next    = ins_off_reg;
        srch_cur_next   = srch_cur_reg;
        col_next        = col_reg;
        mat_next        = mat_reg;
        walk_next       = walk_reg;
        cur_next        = cur_reg;
        cur_fail_next   = cur_fail_reg;
        child_next      = child_reg;
        bsym_next       = bsym_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        swp_next        = swp_reg;
        res_status_next = res_status_reg;
        res_pid_next    = res_pid_reg;
        res_pos_next    = res_pos_reg;
        res_cnt_next    = res_cnt_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tuser_next    = m_tuser_reg;
        m_tdata_next    = m_tdata_reg;
        g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_raddr = '0;
        t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_raddr = '0;
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;

        if (cfg_we)
        begin
            if (cfg_index == REG_PATTERN_LENGTH)
            begin
                pl_next = cfg_wdata[7:0];
            end
            else
            begin
                asz_next = cfg_wdata;
            end
        end

        unique case (cmd.op)
            OP_LOAD:
            begin
                mode_next       = s_tuser;
                sym_next        = s_tdata;
                last_next       = s_tlast;
                res_status_next = ST_OK;
                res_pid_next    = '0;
                res_pos_next    = '0;
                res_cnt_next    = '0;
            end
            OP_RES_PHASE:
            begin
                res_status_next = ST_PHASE;
            end
            OP_RES_BAD_INS:
            begin
                res_status_next = ST_BADSYM;
            end
            OP_RES_BAD_SRCH:
            begin
                res_status_next = ST_BADSYM;
                if (last_reg)
                begin
                    srch_cur_next = '0;
                    col_next      = '0;
                    mat_next      = '0;
                end
            end
            OP_INS_RD:
            begin
                g_raddr = {ins_cur_reg, sym_a};
            end
            OP_INS_CHK:
            begin
                if (full)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    if (g_zero)
                    begin
                        g_we    = 1'b1;
                        g_waddr = {ins_cur_reg, sym_a};
                        g_wdata = EW'(sc_reg + CW'(1));
                        sc_next = sc_reg + CW'(1);
                    end
                    ins_cur_next = nxt;
                    if (close)
                    begin
                        t_raddr = nxt;
                    end
                    else
                    begin
                        ins_off_next = ins_off_reg + 8'd1;
                    end
                end
            end
            OP_INS_TERM:
            begin
                // number a pattern only the first time its end state is reached
                if (t_zero)
                begin
                    t_we    = 1'b1;
                    t_waddr = ins_cur_reg;
                    t_wdata = pc_reg + CW'(1);
                    pc_next = pc_reg + CW'(1);
                end
                ins_cur_next = '0;
                ins_off_next = '0;
            end
            OP_SRCH_RD:
            begin
                walk_next = srch_cur_reg;
                g_raddr   = {srch_cur_reg, sym_a};
            end
            OP_SRCH_CHK:
            begin
                if (g_zero)
                begin
                    f_raddr = walk_reg;
                end
                else
                begin
                    srch_cur_next = g_dec;
                    t_raddr       = g_dec;
                end
            end
            OP_SRCH_FAIL:
            begin
                walk_next = f_rdata;
                g_raddr   = {f_rdata, sym_a};
            end
            OP_SRCH_TERM:
            begin
                res_status_next = t_zero ? ST_OK : ST_MATCH;
                res_pid_next    = t_zero ? '0 : PID_W'(t_rdata - CW'(1));
                res_pos_next    = col_reg;
                res_cnt_next    = mat_new;
                mat_next        = mat_new;
                col_next        = (col_reg != '1) ? col_reg + CNT_W'(1) : col_reg;
                if (last_reg)
                begin
                    srch_cur_next = '0;
                    col_next      = '0;
                    mat_next      = '0;
                end
            end
            OP_ROOT_INIT:
            begin
                bsym_next = '0;
                head_next = '0;
                tail_next = '0;
            end
            OP_ROOT_RD:
            begin
                g_raddr = {SW'(0), bsym_reg};
            end
            OP_ROOT_CHK:
            begin
                // root holes loop back to the root; depth-one states fail to it
                if (g_zero)
                begin
                    g_we    = 1'b1;
                    g_waddr = {SW'(0), bsym_reg};
                    g_wdata = EW'(1);
                end
                else if (g_rdata != EW'(1) && tail_room)
                begin
                    f_we      = 1'b1;
                    f_waddr   = g_dec;
                    f_wdata   = '0;
                    q_we      = 1'b1;
                    q_waddr   = tail_reg[SW-1:0];
                    q_wdata   = g_dec;
                    tail_next = tail_reg + CW'(1);
                end
                bsym_next = bsym_reg + AW'(1);
            end
            OP_DEQ:
            begin
                q_raddr   = head_reg[SW-1:0];
                head_next = head_reg + CW'(1);
            end
            OP_CUR:
            begin
                cur_next  = q_rdata;
                f_raddr   = q_rdata;
                bsym_next = '0;
            end
            OP_CURF:
            begin
                cur_fail_next = f_rdata;
            end
            OP_SYM_RD:
            begin
                g_raddr = {cur_reg, bsym_reg};
            end
            OP_SYM_CHK:
            begin
                if (g_zero)
                begin
                    bsym_next = bsym_reg + AW'(1);
                end
                else
                begin
                    child_next = g_dec;
                    if (tail_room)
                    begin
                        q_we      = 1'b1;
                        q_waddr   = tail_reg[SW-1:0];
                        q_wdata   = g_dec;
                        tail_next = tail_reg + CW'(1);
                    end
                    walk_next = cur_fail_reg;
                    g_raddr   = {cur_fail_reg, bsym_reg};
                end
            end
            OP_WALK:
            begin
                if (g_zero)
                begin
                    f_raddr = walk_reg;
                end
                else
                begin
                    f_we      = 1'b1;
                    f_waddr   = child_reg;
                    f_wdata   = g_dec;
                    bsym_next = bsym_reg + AW'(1);
                end
            end
            OP_WFAIL:
            begin
                walk_next = f_rdata;
                g_raddr   = {f_rdata, bsym_reg};
            end
            OP_BUILD_END:
            begin
                ins_cur_next = '0;
                ins_off_next = '0;
                phase_next   = 1'b1;
            end
            OP_SWEEP_START:
            begin
                swp_next = '0;
            end
            OP_SWEEP:
            begin
                g_we    = 1'b1;
                g_waddr = swp_reg;
                g_wdata = '0;
                if (swp_reg < GW'(MAX_STATES))
                begin
                    t_we    = 1'b1;
                    t_waddr = swp_reg[SW-1:0];
                    t_wdata = '0;
                end
                sc_next       = CW'(1);
                pc_next       = '0;
                ins_cur_next  = '0;
                ins_off_next  = '0;
                srch_cur_next = '0;
                col_next      = '0;
                mat_next      = '0;
                phase_next    = 1'b0;
                swp_next      = swp_reg + GW'(1);
            end
            OP_OUT:
            begin
                m_tvalid_next = 1'b1;
                m_tuser_next  = res_status_reg;
                m_tdata_next  = {NUM_W'(pc_reg), NUM_W'(sc_reg), res_cnt_reg,
                                 res_pos_reg, res_pid_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pl_reg       <= 8'd8;
            asz_reg      <= 9'd256;
            phase_reg    <= 1'b0;
            sc_reg       <= CW'(1);
            pc_reg       <= '0;
            ins_cur_reg  <= '0;
            ins_off_reg  <= '0;
            srch_cur_reg <= '0;
            col_reg      <= '0;
            mat_reg      <= '0;
            bsym_reg     <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            swp_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            pl_reg       <= pl_next;
            asz_reg      <= asz_next;
            phase_reg    <= phase_next;
            sc_reg       <= sc_next;
            pc_reg       <= pc_next;
            ins_cur_reg  <= ins_cur_next;
            ins_off_reg  <= ins_off_next;
            srch_cur_reg <= srch_cur_next;
            col_reg      <= col_next;
            mat_reg      <= mat_next;
            bsym_reg     <= bsym_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            swp_reg      <= swp_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        sym_reg        <= sym_next;
        last_reg       <= last_next;
        walk_reg       <= walk_next;
        cur_reg        <= cur_next;
        cur_fail_reg   <= cur_fail_next;
        child_reg      <= child_next;
        res_status_reg <= res_status_next;
        res_pid_reg    <= res_pid_next;
        res_pos_reg    <= res_pos_next;
        res_cnt_reg    <= res_cnt_next;
        m_tuser_reg    <= m_tuser_next;
        m_tdata_reg    <= m_tdata_next;
    end

    acm_ram #(.WIDTH(EW), .DEPTH(GOTO_DEPTH)) u_goto (
        .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(g_rdata)
    );

    acm_ram #(.WIDTH(CW), .DEPTH(MAX_STATES)) u_term (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    acm_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_fail (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    acm_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

endmodule

@@ src/aho_corasick_matcher.sv @@
// aho_corasick_matcher: top level of the equal-length multi-pattern matcher.
// Depends on acm_pkg, acm_ctrl, acm_dp (and acm_ram through acm_dp).
//
// One input transfer gives exactly one result transfer; items are handled one
// at a time, and the next is taken while the previous result still waits on
// the master side. A pattern byte reads and checks the goto table, adds a
// state where the entry is empty and, at the last byte, numbers the pattern;
// a text byte reads the goto table, follows failure links until a transition
// is found, then reads the terminal table. Building links checks each root
// symbol, then for each dequeued state checks every symbol and walks failure
// links for each child, until the queue is empty. After reset and on a clear
// the goto table is swept one entry a cycle, MAX_STATES * 2**clog2(ALPHABET)
// entries (262144 at the defaults), with s_tready low during the sweep.
module aho_corasick_matcher #(
    parameter int MAX_STATES = 1024,
    parameter int ALPHABET   = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // symbol[7:0]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // pattern_id[9:0], position[25:10],
                                   // match_count[41:26], states_used[52:42],
                                   // patterns_stored[63:53]
    output logic [2:0]  m_tuser    // status[2:0]
);
    import acm_pkg::*;

    cmd_t  dp_cmd;
    stat_t dp_stat;

    assign s_tready = dp_cmd.ready;

    acm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid),
        .stat(dp_stat), .cmd(dp_cmd)
    );

    acm_dp #(.MAX_STATES(MAX_STATES), .ALPHABET(ALPHABET)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tready(m_tready), .cmd(dp_cmd), .stat(dp_stat),
        .m_tvalid(m_tvalid), .m_tuser(m_tuser), .m_tdata(m_tdata)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transfer accepted while an item is in work");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.op == OP_OUT |-> (!m_tvalid || m_tready))
        else $error("result loaded over a pending result");

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(dp_cmd.op == OP_OUT))
        else $error("result valid without a result load");

endmodule
